// ----- hw/rtl/circular_arena_operand_fetch_macros.svh -----
// Assertion helpers shared by the operand fetch block.
// Both sample on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef CIRCULAR_ARENA_OPERAND_FETCH_MACROS_SVH
`define CIRCULAR_ARENA_OPERAND_FETCH_MACROS_SVH

// Same-cycle implication.
`define CAO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("operand fetch: same-cycle check failed");

// Next-cycle implication.
`define CAO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("operand fetch: next-cycle check failed");

`endif

// ----- hw/rtl/cao_pkg.sv -----
package cao_pkg;

  // The arena spans the whole 12-bit address field, so address arithmetic
  // wraps by plain truncation.
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned MEM_BYTES = 4096;

  // Indirect offsets are reduced modulo this range. It must be a power of two
  // so that the remainder of the magnitude is a mask.
  localparam int unsigned IDX_RANGE = 512;
  localparam logic [15:0] IDX_MASK  = 16'(IDX_RANGE - 1);

  // Argument type bits; the lowest set bit wins.
  localparam int unsigned TYPE_REG_BIT = 0;
  localparam int unsigned TYPE_DIR_BIT = 1;
  localparam int unsigned TYPE_IND_BIT = 2;

  typedef enum logic [1:0] {
    CMD_WBYTE = 2'd0,
    CMD_STORE = 2'd1,
    CMD_WREG  = 2'd2,
    CMD_FETCH = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [ADDR_W-1:0]  operand_address;
    logic [ADDR_W-1:0]  process_base;
    logic [2:0]         arg_type;
    logic               long_direct;
    logic signed [31:0] data_word;
    logic [7:0]         byte_value;
    logic [3:0]         reg_select;
  } cao_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
  } cao_out_t;

endpackage

// ----- hw/rtl/circular_arena_operand_fetch.sv -----
// Channel    Direction  Handshake               Payload
// command    in         start & !busy accepts   item_i   (cao_pkg::cao_in_t)
// result     out        result_valid_o strobe   result_o (cao_pkg::cao_out_t)
//
// Every accepted word yields exactly one result word, strobed for one cycle.
// Store word and the register, direct and indirect fetches move their bytes
// over the single byte-wide arena port, one byte a cycle.
// After reset a clearing pass zeroes the arena and register file, one arena
// byte a cycle; busy stays high throughout.
// The receiver cannot stall: results are never held back.
`include "circular_arena_operand_fetch_macros.svh"

module circular_arena_operand_fetch #(
  parameter int unsigned REG_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cao_pkg::cao_in_t  item_i,
  output logic              result_valid_o,
  output cao_pkg::cao_out_t result_o
);

  import cao_pkg::*;

  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STORE,
    S_READ,
    S_REGRD,
    S_REGWAIT
  } state_e;

  // What the byte reader is collecting.
  typedef enum logic [2:0] {
    PH_REGNUM,
    PH_DIR2,
    PH_DIR4,
    PH_OFFSET,
    PH_TARGET
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [2:0]        iss_q, iss_d;
  logic              pend_q, pend_d;
  logic [31:0]       acc_q, acc_d;
  logic [31:0]       data_q, data_d;
  logic [RW-1:0]     rsel_q, rsel_d;
  logic              valid_q, valid_d;
  cao_out_t          res_q, res_d;

  // Arena and register file ports.
  logic              arena_we;
  logic [ADDR_W-1:0] arena_addr;
  logic [7:0]        arena_wdata;
  logic [7:0]        arena_rdata;
  logic              rf_we;
  logic [RW-1:0]     rf_addr;
  logic [31:0]       rf_wdata;
  logic [31:0]       rf_rdata;

  logic        accept;
  logic        issue;
  logic        finish;
  logic [31:0] acc_now;
  logic [7:0]  reg_num;
  logic        reg_ok;
  logic        rsel_ok;
  logic [15:0] off_raw;
  logic [15:0] off_mag;
  logic [15:0] rem_mag;
  logic [15:0] rem_val;
  logic [ADDR_W-1:0] target;

  cao_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_arena (
    .clk_i   (clk_i),
    .we_i    (arena_we),
    .addr_i  (arena_addr),
    .wdata_i (arena_wdata),
    .rdata_o (arena_rdata)
  );

  cao_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regfile (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .addr_i  (rf_addr),
    .wdata_i (rf_wdata),
    .rdata_o (rf_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // The byte reader issues one arena read a cycle; data comes back in the next
  // cycle and is shifted into the accumulator. The last byte lands in the
  // cycle after the last issue, which is when the phase is finished.
  assign issue   = (state_q == S_READ) && (iss_q != 3'd0);
  assign finish  = (state_q == S_READ) && pend_q && (iss_q == 3'd0);
  assign acc_now = {acc_q[23:0], arena_rdata};

  // Register numbers run from one to REG_COUNT.
  assign reg_num = acc_now[7:0];
  assign reg_ok  = (reg_num != 8'd0) && (32'(reg_num) <= REG_COUNT);
  assign rsel_ok = (32'(item_i.reg_select) < REG_COUNT);

  // Indirect target: the remainder truncates toward zero, so it keeps the
  // sign of the offset and masks the magnitude. The sum wraps by truncation.
  assign off_raw = acc_now[15:0];
  assign off_mag = off_raw[15] ? 16'(-off_raw) : off_raw;
  assign rem_mag = off_mag & IDX_MASK;
  assign rem_val = off_raw[15] ? 16'(-rem_mag) : rem_mag;
  assign target  = base_q + rem_val[ADDR_W-1:0];

  // Arena port selection.
  always_comb begin
    arena_we    = 1'b0;
    arena_addr  = ptr_q;
    arena_wdata = data_q[31:24];
    priority if (state_q == S_CLEAR) begin
      arena_we    = 1'b1;
      arena_addr  = clr_q;
      arena_wdata = 8'h00;
    end else if (state_q == S_STORE) begin
      arena_we = 1'b1;
    end else if (accept && (item_i.cmd == CMD_WBYTE)) begin
      arena_we    = 1'b1;
      arena_addr  = item_i.operand_address;
      arena_wdata = item_i.byte_value;
    end else begin
      arena_we = 1'b0;
    end
  end

  // Register file port selection.
  always_comb begin
    rf_we    = 1'b0;
    rf_addr  = rsel_q;
    rf_wdata = 32'd0;
    priority if (state_q == S_CLEAR) begin
      rf_we   = (32'(clr_q) < REG_COUNT);
      rf_addr = clr_q[RW-1:0];
    end else if (accept && (item_i.cmd == CMD_WREG)) begin
      rf_we    = rsel_ok;
      rf_addr  = RW'(item_i.reg_select);
      rf_wdata = item_i.data_word;
    end else begin
      rf_we = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    clr_d   = clr_q;
    ptr_d   = ptr_q;
    base_d  = base_q;
    iss_d   = iss_q;
    pend_d  = issue;
    acc_d   = acc_q;
    data_d  = data_q;
    rsel_d  = rsel_q;
    valid_d = 1'b0;
    res_d   = '0;

    if (issue) begin
      ptr_d = ptr_q + 1'b1;
      iss_d = iss_q - 3'd1;
    end
    if (pend_q) begin
      acc_d = acc_now;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(MEM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ptr_d  = item_i.operand_address;
          base_d = item_i.process_base;
          data_d = item_i.data_word;
          unique case (item_i.cmd)
            CMD_WBYTE, CMD_WREG: begin
              valid_d = 1'b1;
            end
            CMD_STORE: begin
              iss_d   = 3'd4;
              state_d = S_STORE;
            end
            CMD_FETCH: begin
              priority if (item_i.arg_type[TYPE_REG_BIT]) begin
                phase_d = PH_REGNUM;
                iss_d   = 3'd1;
                state_d = S_READ;
              end else if (item_i.arg_type[TYPE_DIR_BIT]) begin
                phase_d = item_i.long_direct ? PH_DIR4 : PH_DIR2;
                iss_d   = item_i.long_direct ? 3'd4 : 3'd2;
                state_d = S_READ;
              end else if (item_i.arg_type[TYPE_IND_BIT]) begin
                phase_d = PH_OFFSET;
                iss_d   = 3'd2;
                state_d = S_READ;
              end else begin
                valid_d     = 1'b1;
                res_d.error = 1'b1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_STORE: begin
        ptr_d  = ptr_q + 1'b1;
        iss_d  = iss_q - 3'd1;
        data_d = {data_q[23:0], 8'h00};
        if (iss_q == 3'd1) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (finish) begin
          unique case (phase_q)
            PH_REGNUM: begin
              if (reg_ok) begin
                rsel_d  = RW'(8'(reg_num - 8'd1));
                state_d = S_REGRD;
              end else begin
                valid_d     = 1'b1;
                res_d.error = 1'b1;
                state_d     = S_IDLE;
              end
            end
            PH_DIR2: begin
              valid_d     = 1'b1;
              res_d.value = {{16{acc_now[15]}}, acc_now[15:0]};
              state_d     = S_IDLE;
            end
            PH_OFFSET: begin
              ptr_d   = target;
              iss_d   = 3'd4;
              phase_d = PH_TARGET;
            end
            PH_DIR4, PH_TARGET: begin
              valid_d     = 1'b1;
              res_d.value = acc_now;
              state_d     = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_REGRD: begin
        state_d = S_REGWAIT;
      end
      S_REGWAIT: begin
        valid_d     = 1'b1;
        res_d.value = rf_rdata;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      phase_q <= PH_REGNUM;
      clr_q   <= '0;
      ptr_q   <= '0;
      base_q  <= '0;
      iss_q   <= '0;
      pend_q  <= 1'b0;
      acc_q   <= '0;
      data_q  <= '0;
      rsel_q  <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      clr_q   <= clr_d;
      ptr_q   <= ptr_d;
      base_q  <= base_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      acc_q   <= acc_d;
      data_q  <= data_d;
      rsel_q  <= rsel_d;
      valid_q <= valid_d;
      res_q   <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // Nothing is reported while the arena is still being cleared.
  `CAO_ASSERT_IMP(a_no_result_in_clear, state_q == S_CLEAR, !result_valid_o)
  // A byte write answers in the next cycle with a zero result.
  `CAO_ASSERT_NXT(a_wbyte_answers, accept && (item_i.cmd == CMD_WBYTE),
                  result_valid_o && (result_o.value == 32'sd0) && !result_o.error)
  // The reader never leaves a byte in flight once the block goes idle.
  `CAO_ASSERT_IMP(a_idle_no_pending, !busy, !pend_q)
  // The arena is never written while operand bytes are being read.
  `CAO_ASSERT_IMP(a_no_write_in_read, state_q == S_READ, !arena_we)

endmodule

// ----- hw/rtl/cao_ram.sv -----
module cao_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
